// ===== design/sfd_pkg.sv =====
// shared types, constants and helpers for the sample frame deframer
`default_nettype none

package sfd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned SampleW = 16;
  localparam int unsigned CountW  = 15;
  localparam int unsigned KindW   = 2;
  localparam int unsigned OutDataW = 32;

  localparam logic [CountW-1:0] ExpectedReset = 15'd1024;

  localparam logic [ByteW-1:0] SyncS = 8'h53;
  localparam logic [ByteW-1:0] SyncT = 8'h54;
  localparam logic [ByteW-1:0] SyncA = 8'h41;
  localparam logic [ByteW-1:0] SyncR = 8'h52;

  typedef enum logic [KindW-1:0] {
    KIND_HDR_OK  = 2'd0,
    KIND_LEN_ERR = 2'd1,
    KIND_SAMPLE  = 2'd2
  } sfd_kind_e;

  typedef struct packed {
    sfd_kind_e                 kind;
    logic signed [SampleW-1:0] sample;
    logic [CountW-1:0]         count;
    logic                      last;
  } sfd_result_t;

  // expected letter of the sync word after idx letters matched
  function automatic logic [ByteW-1:0] sync_letter(input logic [2:0] idx);
    logic [ByteW-1:0] letter;
    case (idx)
      3'd0:    letter = SyncS;
      3'd1:    letter = SyncT;
      3'd2:    letter = SyncA;
      3'd3:    letter = SyncR;
      default: letter = SyncT;
    endcase
    return letter;
  endfunction

endpackage

`default_nettype wire

// ===== design/sfd_parser.sv =====
// frame parser: sync hunt, length check and sample assembly, one byte per transfer
`default_nettype none

module sfd_parser
  import sfd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              fire_i,
  input  wire logic [ByteW-1:0]  byte_i,
  input  wire logic [CountW-1:0] expected_i,
  output logic                   res_valid_o,
  output sfd_result_t            res_o
);

  typedef enum logic [3:0] {
    PH_HUNT0  = 4'd0,
    PH_HUNT1  = 4'd1,
    PH_HUNT2  = 4'd2,
    PH_HUNT3  = 4'd3,
    PH_HUNT4  = 4'd4,
    PH_LEN_LO = 4'd5,
    PH_LEN_HI = 4'd6,
    PH_SMP_LO = 4'd7,
    PH_SMP_HI = 4'd8
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [ByteW-1:0]  len_lo_q, len_lo_d;
  logic [ByteW-1:0]  smp_lo_q, smp_lo_d;
  logic [CountW-1:0] left_q, left_d;

  logic [2:0]         hunt_idx;
  logic [SampleW-1:0] len_word;
  logic [SampleW-1:0] smp_word;
  logic [CountW-1:0]  count;
  logic [CountW-1:0]  left_dec;
  logic               res_valid;
  sfd_result_t        res;

  assign len_word = {byte_i, len_lo_q};
  assign smp_word = {byte_i, smp_lo_q};
  assign count    = len_word[SampleW-1:1];
  assign left_dec = left_q - 15'd1;
  assign hunt_idx = (phase_q <= PH_HUNT4) ? phase_q[2:0] : 3'd0;

  always_comb begin
    phase_d    = phase_q;
    len_lo_d   = len_lo_q;
    smp_lo_d   = smp_lo_q;
    left_d     = left_q;
    res_valid  = 1'b0;
    res.kind   = KIND_HDR_OK;
    res.sample = '0;
    res.count  = '0;
    res.last   = 1'b0;
    case (phase_q)
      PH_LEN_LO: begin
        len_lo_d = byte_i;
        phase_d  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        res_valid = 1'b1;
        res.count = count;
        if (count == expected_i) begin
          res.kind = KIND_HDR_OK;
          left_d   = count;
          phase_d  = (count != '0) ? PH_SMP_LO : PH_HUNT0;
        end else begin
          res.kind = KIND_LEN_ERR;
          phase_d  = PH_HUNT0;
        end
      end
      PH_SMP_LO: begin
        smp_lo_d = byte_i;
        phase_d  = PH_SMP_HI;
      end
      PH_SMP_HI: begin
        res_valid  = 1'b1;
        res.kind   = KIND_SAMPLE;
        res.sample = signed'(smp_word);
        res.last   = (left_dec == '0);
        left_d     = left_dec;
        phase_d    = (left_dec == '0) ? PH_HUNT0 : PH_SMP_LO;
      end
      default: begin
        // hunting, unused codes behave as nothing matched
        if (byte_i == sync_letter(hunt_idx)) begin
          phase_d = phase_e'({1'b0, hunt_idx} + 4'd1);
        end else if (byte_i == SyncS) begin
          phase_d = PH_HUNT1;
        end else begin
          phase_d = PH_HUNT0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT0;
      len_lo_q <= '0;
      smp_lo_q <= '0;
      left_q   <= '0;
    end else if (fire_i) begin
      phase_q  <= phase_d;
      len_lo_q <= len_lo_d;
      smp_lo_q <= smp_lo_d;
      left_q   <= left_d;
    end
  end

  assign res_valid_o = fire_i & res_valid;
  assign res_o       = res;

endmodule

`default_nettype wire

// ===== design/sfd_out_reg.sv =====
// result register driving the master-side stream
`default_nettype none

module sfd_out_reg
  import sfd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire sfd_result_t res_i,
  output logic             free_o,
  output logic             valid_o,
  input  wire logic        ready_i,
  output sfd_result_t      res_o
);

  logic        valid_q, valid_d;
  sfd_result_t res_q;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (push_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

// ===== design/sample_frame_deframer_core.sv =====
// top level of the sample frame deframer
// Takes one received byte per transfer and finds frames of the form "START",
// a 16-bit little-endian byte length, then that many bytes of little-endian
// int16 samples. The length is checked against expected_samples at the length
// high byte: a match gives a header-accepted result followed by one result per
// sample (tlast on the final one), a mismatch gives one mismatch result and the
// hunt resumes. A byte is taken every cycle while the master side does not stall;
// each one is held in the input register and the parser writes its result, if
// any, into the result register, which drives the master side. The only stall
// comes from the master side holding tready low.
`default_nettype none

module sample_frame_deframer_core
  import sfd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_wr_en_i,
  input  wire logic [CountW-1:0]    cfg_wr_data_i,   // expected_samples
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [ByteW-1:0]     s_axis_tdata,    // [7:0] rx_byte
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [OutDataW-1:0]       m_axis_tdata,    // [15:0] sample_value, [30:16] reported_count
  output logic [KindW-1:0]          m_axis_tuser,    // [1:0] result_kind
  output logic                      m_axis_tlast     // last_sample
);

  logic [CountW-1:0] expected_q;
  logic              in_valid_q;
  logic [ByteW-1:0]  in_byte_q;
  logic              out_free;
  logic              fire;
  logic              push;
  sfd_result_t       res;
  sfd_result_t       out_res;

  assign fire          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q <= ExpectedReset;
    end else if (cfg_wr_en_i) begin
      expected_q <= cfg_wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  sfd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .byte_i      (in_byte_q),
    .expected_i  (expected_q),
    .res_valid_o (push),
    .res_o       (res)
  );

  sfd_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .res_i   (res),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (out_res)
  );

  assign m_axis_tdata = {1'b0, out_res.count, out_res.sample};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;

endmodule

`default_nettype wire

// ===== design/sfd_checker.sv =====
// port-level checks for the sample frame deframer, bound to the top level
`default_nettype none

module sfd_checker
  import sfd_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 s_axis_tvalid,
  input wire logic                 s_axis_tready,
  input wire logic                 m_axis_tvalid,
  input wire logic                 m_axis_tready,
  input wire logic [OutDataW-1:0]  m_axis_tdata,
  input wire logic [KindW-1:0]     m_axis_tuser,
  input wire logic                 m_axis_tlast
);

  // stalled result transfer holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == KIND_SAMPLE)
    else $error("tlast on a header result");

  a_hdr_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != KIND_SAMPLE |-> m_axis_tdata[15:0] == 16'd0)
    else $error("header result carries sample bits");

  a_smp_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_SAMPLE |-> m_axis_tdata[31:16] == 16'd0)
    else $error("sample result carries count bits");

  // no result without an earlier byte transfer
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2)
      || $past(m_axis_tvalid && m_axis_tready))
    else $error("result without a byte");

endmodule

bind sample_frame_deframer_core sfd_checker u_sfd_checker (.*);

`default_nettype wire

// ===== verif/tb_sample_frame_deframer_core.sv =====
// testbench for sample_frame_deframer_core: directed table then random frames, checked by a predictor
`default_nettype none

module tb_sample_frame_deframer_core;
  import sfd_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_SMP_LO,
    PH_SMP_HI
  } frame_phase_e;

  typedef enum logic {
    ROW_BYTE,
    ROW_CFG
  } row_op_e;

  typedef struct {
    row_op_e     op;
    logic [15:0] value;
    bit          pinned;
    sfd_result_t result;
  } stim_row_t;

  localparam logic [5*ByteW-1:0] SyncWord = {SyncT, SyncR, SyncA, SyncT, SyncS};
  localparam int unsigned TotalBytes = 850;
  localparam int unsigned RandPhases = 10;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned DrainCycles = 4;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_wr_en_i = 1'b0;
  logic [CountW-1:0]   cfg_wr_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [ByteW-1:0]    s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [KindW-1:0]    m_axis_tuser;
  logic                m_axis_tlast;

  // typed-in expectation travelling with the byte on the bus
  bit          pin_valid = 1'b0;
  sfd_result_t pin_result;

  // predictor state
  frame_phase_e      frame_phase = PH_HUNT;
  logic [2:0]        hunt_matched = '0;
  logic [ByteW-1:0]  len_lo_q = '0;
  logic [ByteW-1:0]  smp_lo_q = '0;
  logic [CountW-1:0] samples_left_q = '0;
  logic [CountW-1:0] expected_samples_q = ExpectedReset;

  sfd_result_t    pending_results[$];
  sfd_result_t    predicted;
  sfd_result_t    want_result;
  sfd_result_t    blank_result;
  stim_row_t      directed_rows[$];
  int unsigned    mismatch_count = 0;
  int unsigned    bytes_sent = 0;
  logic [CountW-1:0] cur_cfg = ExpectedReset;
  bit             steady = 1'b0;
  bit             hold_off_pending = 1'b0;

  sample_frame_deframer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #2 clk_i = ~clk_i;

  function automatic bit deframe_byte(input logic [ByteW-1:0] b, output sfd_result_t res);
    logic [CountW-1:0] cnt;
    res.kind   = KIND_HDR_OK;
    res.sample = '0;
    res.count  = '0;
    res.last   = 1'b0;
    deframe_byte = 1'b0;
    case (frame_phase)
      PH_HUNT: begin
        if (b == SyncWord[8*hunt_matched +: 8]) begin
          if (hunt_matched == 3'd4) begin
            hunt_matched = '0;
            frame_phase = PH_LEN_LO;
          end else begin
            hunt_matched = hunt_matched + 3'd1;
          end
        end else if (b == SyncS) begin
          hunt_matched = 3'd1;
        end else begin
          hunt_matched = '0;
        end
      end
      PH_LEN_LO: begin
        len_lo_q = b;
        frame_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        cnt = {b, len_lo_q[7:1]};
        res.count = cnt;
        deframe_byte = 1'b1;
        if (cnt == expected_samples_q) begin
          res.kind = KIND_HDR_OK;
          samples_left_q = cnt;
          frame_phase = (cnt != '0) ? PH_SMP_LO : PH_HUNT;
        end else begin
          res.kind = KIND_LEN_ERR;
          frame_phase = PH_HUNT;
        end
      end
      PH_SMP_LO: begin
        smp_lo_q = b;
        frame_phase = PH_SMP_HI;
      end
      default: begin
        samples_left_q = samples_left_q - 1'b1;
        res.kind = KIND_SAMPLE;
        res.sample = {b, smp_lo_q};
        res.last = (samples_left_q == '0);
        frame_phase = res.last ? PH_HUNT : PH_SMP_LO;
        deframe_byte = 1'b1;
      end
    endcase
  endfunction

  // predict on every input transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_wr_en_i) expected_samples_q = cfg_wr_data_i;
      if (s_axis_tvalid && s_axis_tready) begin
        if (deframe_byte(s_axis_tdata, predicted)) begin
          pending_results.push_back(pin_valid ? pin_result : predicted);
        end
      end
    end
  end

  // compare every output transfer with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d, data %h", m_axis_tuser, m_axis_tdata);
        mismatch_count++;
      end else begin
        want_result = pending_results.pop_front();
        if (m_axis_tuser !== want_result.kind) begin
          $error("result_kind: expected %0d, got %0d", want_result.kind, m_axis_tuser);
          mismatch_count++;
        end
        if (m_axis_tdata[15:0] !== want_result.sample) begin
          $error("sample_value: expected %0d, got %0d", want_result.sample,
                 $signed(m_axis_tdata[15:0]));
          mismatch_count++;
        end
        if (m_axis_tdata[30:16] !== want_result.count) begin
          $error("reported_count: expected %0d, got %0d", want_result.count,
                 m_axis_tdata[30:16]);
          mismatch_count++;
        end
        if (m_axis_tlast !== want_result.last) begin
          $error("last_sample: expected %0d, got %0d", want_result.last, m_axis_tlast);
          mismatch_count++;
        end
      end
    end
  end

  function automatic int unsigned idle_len();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 30);
  endfunction

  // receiver side
  initial begin
    @(posedge clk_i);
    forever begin
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end else if (!steady && $urandom_range(0, 99) < 30) begin
        m_axis_tready <= 1'b0;
        repeat (idle_len()) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic push_byte(input logic [ByteW-1:0] b, input bit pin, input sfd_result_t res);
    int unsigned gap;
    gap = (steady || $urandom_range(0, 99) < 55) ? 0 : idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    pin_valid <= pin;
    pin_result <= res;
    bytes_sent++;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  task automatic push_random(input logic [ByteW-1:0] b);
    push_byte(b, 1'b0, blank_result);
  endtask

  // wait until every result is back and the pipeline is empty
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CountW-1:0] v);
    cfg_wr_en_i <= 1'b1;
    cfg_wr_data_i <= v;
    cur_cfg = v;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
  endtask

  function automatic logic [ByteW-1:0] noise_byte();
    if ($urandom_range(0, 99) < 25) return SyncWord[8*$urandom_range(0, 4) +: 8];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic add_row(input row_op_e op, input logic [15:0] v, input bit pin,
                         input sfd_kind_e kind, input logic [15:0] smp,
                         input logic [CountW-1:0] cnt, input logic lst);
    stim_row_t row;
    row.op = op;
    row.value = v;
    row.pinned = pin;
    row.result.kind = kind;
    row.result.sample = smp;
    row.result.count = cnt;
    row.result.last = lst;
    directed_rows.push_back(row);
  endtask

  task automatic add_byte(input logic [ByteW-1:0] b);
    add_row(ROW_BYTE, {8'h00, b}, 1'b0, KIND_HDR_OK, '0, '0, 1'b0);
  endtask

  task automatic add_sync();
    for (int i = 0; i < 5; i++) add_byte(SyncWord[8*i +: 8]);
  endtask

  task automatic send_frame();
    int unsigned noise;
    int unsigned r;
    int unsigned nsamp;
    logic [15:0] len;
    logic [15:0] smp;
    noise = ($urandom_range(0, 99) < 70) ? 0 : $urandom_range(1, 4);
    repeat (noise) push_random(noise_byte());
    r = $urandom_range(0, 99);
    if (r < 10) begin
      // broken sync word
      for (int i = 0; i < $urandom_range(1, 4); i++) push_random(SyncWord[8*i +: 8]);
      push_random(noise_byte());
      return;
    end
    for (int i = 0; i < 5; i++) push_random(SyncWord[8*i +: 8]);
    if (r < 80 && cur_cfg <= 64) begin
      len = {cur_cfg, 1'b0} | 16'($urandom_range(0, 1));
    end else begin
      len = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(0, 65535))
                                        : {cur_cfg + 15'($urandom_range(0, 1) ? 1 : -1), 1'b0};
      if (len[15:1] == cur_cfg) len[1] = ~len[1];
    end
    push_random(len[7:0]);
    push_random(len[15:8]);
    if (len[15:1] == cur_cfg && cur_cfg != '0) begin
      nsamp = 32'(cur_cfg);
      if (nsamp > 1 && $urandom_range(0, 99) < 5) nsamp = $urandom_range(1, nsamp - 1);
      repeat (nsamp) begin
        case ($urandom_range(0, 39))
          0:       smp = 16'h8000;
          1:       smp = 16'h7FFF;
          2:       smp = 16'hFFFF;
          3:       smp = 16'h0000;
          default: smp = 16'($urandom_range(0, 65535));
        endcase
        push_random(smp[7:0]);
        push_random(smp[15:8]);
      end
    end
  endtask

  initial begin
    stim_row_t   row;
    int unsigned target;
    blank_result.kind = KIND_HDR_OK;
    blank_result.sample = '0;
    blank_result.count = '0;
    blank_result.last = 1'b0;
    pin_result = blank_result;

    // reset value of the register: noise, repeated sync letter, top length rejected
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(SyncS);
    add_sync();
    add_byte(8'hFF);
    add_row(ROW_BYTE, 16'h00FF, 1'b1, KIND_LEN_ERR, '0, 15'd32767, 1'b0);
    // empty frame accepted, odd length
    add_row(ROW_CFG, 16'd0, 1'b0, KIND_HDR_OK, '0, '0, 1'b0);
    add_sync();
    add_byte(8'h01);
    add_row(ROW_BYTE, 16'h0000, 1'b1, KIND_HDR_OK, '0, 15'd0, 1'b0);
    // two samples at the extremes
    add_row(ROW_CFG, 16'd2, 1'b0, KIND_HDR_OK, '0, '0, 1'b0);
    add_sync();
    add_byte(8'h04);
    add_row(ROW_BYTE, 16'h0000, 1'b1, KIND_HDR_OK, '0, 15'd2, 1'b0);
    add_byte(8'h00);
    add_row(ROW_BYTE, 16'h0080, 1'b1, KIND_SAMPLE, 16'h8000, '0, 1'b0);
    add_byte(8'hFF);
    add_row(ROW_BYTE, 16'h007F, 1'b1, KIND_SAMPLE, 16'h7FFF, '0, 1'b1);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.op == ROW_CFG) begin
        settle();
        write_cfg(row.value[CountW-1:0]);
      end else begin
        push_byte(row.value[7:0], row.pinned, row.result);
      end
    end

    for (int p = 0; p < RandPhases; p++) begin
      settle();
      steady = (p % 4 == 1);
      case (p)
        2:       write_cfg(15'd0);
        3:       write_cfg(15'd32767);
        default: write_cfg(15'($urandom_range(1, 8)));
      endcase
      if (p == 1 || p == 6) hold_off_pending = 1'b1;
      target = bytes_sent + (TotalBytes - bytes_sent) / (RandPhases - p);
      while (bytes_sent < target) send_frame();
    end

    settle();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
design/sfd_pkg.sv
design/sfd_parser.sv
design/sfd_out_reg.sv
design/sample_frame_deframer_core.sv
design/sfd_checker.sv
verif/tb_sample_frame_deframer_core.sv
